### hw/rtl/bsc_pkg.sv
// Shared widths and register index codes for the bright square counter.
`default_nettype none

package bsc_pkg;

    localparam int PIXEL_W      = 16;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_SQUARE_W = 5;
    localparam int THRESH_W     = 16;
    localparam int COUNT_W      = 32;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_IDX_IMAGE_WIDTH = 2'd0;
    localparam cfg_index_t CFG_IDX_SQUARE_SIZE = 2'd1;
    localparam cfg_index_t CFG_IDX_THRESHOLD   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

### hw/rtl/bright_square_counter.sv
// An accepted pixel passes the s1_ back-stage and m_ output registers.
// Throughput: one pixel per cycle unless the m_ side stalls; the column counter
// RAM takes a read and a write per cycle, bypassed when both hit one column.
// Reset: synchronous, active low; clears control state and registers to their
// reset values. No clearing pass: a fill count marks column entries never written.
`default_nettype none

module bright_square_counter
    import bsc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_SQUARE = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // pixel stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // [15:0] pixel
    input  wire logic                   s_tuser,   // [0] frame_start
    // result stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [31:0]            m_tdata,   // [31:0] square_count
    output logic                        m_tuser    // [0] square_found
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FW   = $clog2(MAX_WIDTH + 1);
    localparam int WCW  = (FW > CFG_WIDTH_W) ? FW : CFG_WIDTH_W;
    localparam int KW   = $clog2(MAX_SQUARE + 1);
    localparam int SW   = (KW > CFG_SQUARE_W) ? KW : CFG_SQUARE_W;

    // configuration
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_SQUARE_W-1:0] square_size_reg;
    logic [THRESH_W-1:0]     threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= CFG_WIDTH_W'(1024);
            square_size_reg <= CFG_SQUARE_W'(5);
            threshold_reg   <= THRESH_W'(13107);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_IDX_IMAGE_WIDTH: image_width_reg <= cfg_wr_data[CFG_WIDTH_W-1:0];
                CFG_IDX_SQUARE_SIZE: square_size_reg <= cfg_wr_data[CFG_SQUARE_W-1:0];
                CFG_IDX_THRESHOLD:   threshold_reg   <= cfg_wr_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective width and square size after clamping
    logic [WCW-1:0] eff_width;
    logic [KW-1:0]  eff_square;

    always_comb begin
        if (image_width_reg == '0) begin
            eff_width = WCW'(1);
        end else if (WCW'(image_width_reg) > WCW'(MAX_WIDTH)) begin
            eff_width = WCW'(MAX_WIDTH);
        end else begin
            eff_width = WCW'(image_width_reg);
        end
        if (square_size_reg == '0) begin
            eff_square = KW'(1);
        end else if (SW'(square_size_reg) > SW'(MAX_SQUARE)) begin
            eff_square = KW'(MAX_SQUARE);
        end else begin
            eff_square = KW'(square_size_reg);
        end
    end

    // front stage: row run and column position, updated at accept
    logic [KW-1:0] row_run_reg, row_run_next;
    logic [CW-1:0] column_index_reg, column_index_next;
    logic          first_row_reg, first_row_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [KW-1:0] rr_base, rr_new;
    logic [CW-1:0] col;
    logic          first_cur;
    logic          full;
    logic          row_end;
    logic          s_accept;

    // back stage
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_full_reg;
    logic          s1_first_reg;
    logic          s1_frame_reg;
    logic          s1_empty_reg;
    logic          s1_bypass_reg;
    logic [KW-1:0] s1_bypass_data_reg;
    logic          s1_advance;

    logic [KW-1:0] ram_rd_data;
    logic [KW-1:0] cr_base, cr;
    logic          found;
    logic [COUNT_W-1:0] total_base, total_new;
    logic [COUNT_W-1:0] found_total_reg;

    logic          m_tvalid_reg;
    logic          m_found_reg;
    logic [COUNT_W-1:0] m_count_reg;

    assign s_accept   = s_tvalid && s_tready;
    assign s1_advance = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_comb begin
        rr_base   = s_tuser ? '0 : row_run_reg;
        col       = s_tuser ? '0 : column_index_reg;
        first_cur = s_tuser ? 1'b1 : first_row_reg;
        if (s_tdata[PIXEL_W-1:0] > threshold_reg) begin
            rr_new = (rr_base < eff_square) ? rr_base + KW'(1) : rr_base;
            if (rr_new > eff_square) begin
                rr_new = eff_square;
            end
        end else begin
            rr_new = '0;
        end
        full    = (rr_new >= eff_square);
        row_end = (WCW'(col) + WCW'(1) >= eff_width);

        row_run_next      = row_run_reg;
        column_index_next = column_index_reg;
        first_row_next    = first_row_reg;
        if (s_accept) begin
            if (row_end) begin
                row_run_next      = '0;
                column_index_next = '0;
                first_row_next    = 1'b0;
            end else begin
                row_run_next      = rr_new;
                column_index_next = col + CW'(1);
                first_row_next    = first_cur;
            end
        end
    end

    // back stage: column counter update and running total
    always_comb begin
        if (s1_bypass_reg) begin
            cr_base = s1_bypass_data_reg;
        end else if (s1_empty_reg) begin
            cr_base = '0;
        end else begin
            cr_base = ram_rd_data;
        end
        if (!s1_full_reg) begin
            cr = '0;
        end else if (s1_first_reg) begin
            cr = KW'(1);
        end else begin
            cr = (cr_base < eff_square) ? cr_base + KW'(1) : cr_base;
            if (cr > eff_square) begin
                cr = eff_square;
            end
        end
        found      = s1_full_reg && (cr >= eff_square);
        total_base = s1_frame_reg ? '0 : found_total_reg;
        total_new  = (found && total_base != COUNT_MAX) ? total_base + COUNT_W'(1)
                                                        : total_base;
        // columns are written in order from zero, so the fill count is a high mark
        fill_next = fill_reg;
        if (s1_advance && (FW'(s1_col_reg) + FW'(1) > fill_reg)) begin
            fill_next = FW'(s1_col_reg) + FW'(1);
        end
    end

    bsc_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_WIDTH)
    ) u_column_runs (
        .aclk    (aclk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (cr),
        .rd_en   (s_accept),
        .rd_addr (col),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_run_reg      <= '0;
            column_index_reg <= '0;
            first_row_reg    <= 1'b1;
            fill_reg         <= '0;
            found_total_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            row_run_reg      <= row_run_next;
            column_index_reg <= column_index_next;
            first_row_reg    <= first_row_next;
            fill_reg         <= fill_next;
            if (s1_advance) begin
                found_total_reg <= total_new;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_col_reg         <= col;
            s1_full_reg        <= full;
            s1_first_reg       <= first_cur;
            s1_frame_reg       <= s_tuser;
            s1_empty_reg       <= (FW'(col) >= fill_reg);
            // forward the column being written in this same cycle
            s1_bypass_reg      <= s1_advance && (s1_col_reg == col);
            s1_bypass_data_reg <= cr;
        end
        if (s1_advance) begin
            m_found_reg <= found;
            m_count_reg <= total_new;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_count_reg;

`ifndef SYNTHESIS
    a_found_counts : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_found_reg |-> m_count_reg != '0)
        else $error("square found with zero count");

    // the front-stage column index may still be one past the fill mark
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        FW'(column_index_reg) <= fill_reg + FW'(1))
        else $error("column index beyond fill mark");

    a_run_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        row_run_reg <= KW'(MAX_SQUARE))
        else $error("row run above square size");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_tvalid_reg && !m_tready |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("back stage lost a stalled request");
`endif

endmodule

`default_nettype wire

### hw/rtl/bsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for bright_square_counter: directed and random pixel streams checked by a predictor.
module tb;
    import bsc_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_SQUARE    = 16;
    localparam int RANDOM_PIXELS = 380;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam cfg_index_t CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
    } square_result_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    cfg_index_t            cfg_wr_index = CFG_IDX_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata      = '0;   // [15:0] pixel
    logic                  s_tuser      = 1'b0; // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [31:0]           m_tdata;             // [31:0] square_count
    logic                  m_tuser;             // [0] square_found

    bright_square_counter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Predictor copy of the registers and the scan state
    logic [CFG_WIDTH_W-1:0]  width_reg  = 11'd1024;
    logic [CFG_SQUARE_W-1:0] size_reg   = 5'd5;
    logic [THRESH_W-1:0]     thresh_reg = 16'd13107;
    logic [4:0]              col_depth [MAX_WIDTH] = '{default: '0};
    int unsigned             streak      = 0;
    int unsigned             col_pos     = 0;
    bit                      top_row     = 1'b1;
    logic [COUNT_W-1:0]      frame_total = '0;

    square_result_t expected_results[$];
    int unsigned    sent_pixels  = 0;
    int unsigned    mismatches   = 0;
    int unsigned    cycle_count  = 0;
    int unsigned    hold_request = 0;
    bit             quiet        = 1'b0;

    function automatic int unsigned row_length();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned side_length();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_SQUARE) return MAX_SQUARE;
        return size_reg;
    endfunction

    function automatic square_result_t track_squares(logic [15:0] pix, logic fs);
        int unsigned    k;
        int unsigned    w;
        int unsigned    depth;
        bit             full;
        square_result_t r;
        k = side_length();
        w = row_length();
        if (fs) begin
            frame_total = '0;
            streak      = 0;
            col_pos     = 0;
            top_row     = 1'b1;
        end
        if (pix > thresh_reg) begin
            if (streak < k) streak++;
            if (streak > k) streak = k;
        end else begin
            streak = 0;
        end
        full = (streak >= k);
        // the top row restarts the column depth from the horizontal run alone
        if (!full) begin
            depth = 0;
        end else if (top_row) begin
            depth = 1;
        end else begin
            depth = col_depth[col_pos];
            if (depth < k) depth++;
            if (depth > k) depth = k;
        end
        col_depth[col_pos] = 5'(depth);
        r.found = full && (depth >= k);
        if (r.found && frame_total != COUNT_MAX) frame_total++;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            streak  = 0;
            top_row = 1'b0;
        end else begin
            col_pos++;
        end
        r.count = frame_total;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_pixel(int unsigned bright_pct);
        if (bright_pct < 100 && $urandom_range(0, 9) == 0) return 16'($urandom);
        if (thresh_reg != 16'hFFFF && $urandom_range(0, 99) < bright_pct)
            return 16'($urandom_range(int'(thresh_reg) + 1, 16'hFFFF));
        return 16'($urandom_range(0, int'(thresh_reg)));
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_IDX_IMAGE_WIDTH: width_reg  = data[CFG_WIDTH_W-1:0];
            CFG_IDX_SQUARE_SIZE: size_reg   = data[CFG_SQUARE_W-1:0];
            CFG_IDX_THRESHOLD:   thresh_reg = data[THRESH_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(logic [15:0] pix, logic fs);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_results.push_back(track_squares(pix, fs));
        sent_pixels++;
        gap = quiet ? 0 : gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_frame(int unsigned bright_pct);
        int unsigned w;
        int unsigned k;
        int unsigned total;
        bit          fresh;
        w     = row_length();
        k     = side_length();
        total = $urandom_range(1, k + 2) * w + $urandom_range(0, w - 1);
        fresh = ($urandom_range(0, 9) != 0);
        for (int unsigned i = 0; i < total; i++)
            send_pixel(pick_pixel(bright_pct), (i == 0 && fresh) || $urandom_range(0, 99) == 0);
    endtask

    task automatic test_defaults();
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'd13107, 1'b0);
        send_pixel(16'd13108, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        drain_results();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'd1);
        write_reg(CFG_IDX_THRESHOLD, 16'd0);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h8000, 1'b0);
        drain_results();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd1024);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'd16);
        write_reg(CFG_IDX_THRESHOLD, 16'hFFFF);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        drain_results();
    endtask

    task automatic test_clamped_config();
        // zero width and size fall back to one; upper bits are junk
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'hF800);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'hFFE0);
        write_reg(CFG_IDX_THRESHOLD, 16'd1000);
        send_pixel(16'd2000, 1'b1);
        send_pixel(16'd500, 1'b0);
        send_pixel(16'd2000, 1'b0);
        drain_results();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'h07FF);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'h001F);
        send_pixel(16'hFFFF, 1'b1);
        drain_results();
        // an unused register index must change nothing
        write_reg(CFG_IDX_UNUSED, 16'h0003);
        send_pixel(16'hFFFF, 1'b0);
        drain_results();
    endtask

    task automatic test_width_change();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd6);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'd2);
        write_reg(CFG_IDX_THRESHOLD, 16'd100);
        send_pixel(16'd200, 1'b1);
        send_pixel(16'd200, 1'b0);
        send_pixel(16'd200, 1'b0);
        drain_results();
        // shrink below the current column: the row ends on the next pixel
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd2);
        repeat (4) send_pixel(16'd200, 1'b0);
        // frame start at the beginning of a row
        send_pixel(16'd300, 1'b0);
        send_pixel(16'd300, 1'b1);
        send_pixel(16'd300, 1'b0);
        drain_results();
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd64);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'd1);
        write_reg(CFG_IDX_THRESHOLD, 16'($urandom_range(0, 60000)));
        quiet        = 1'b1;
        hold_request = 200;
        for (int i = 0; i < 70; i++) send_pixel(pick_pixel(70), i == 0);
        quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_largest_square();
        write_reg(CFG_IDX_IMAGE_WIDTH, 16'd16);
        write_reg(CFG_IDX_SQUARE_SIZE, 16'd16);
        write_reg(CFG_IDX_THRESHOLD, 16'($urandom_range(0, 50000)));
        for (int i = 0; i < 17 * 16; i++) send_pixel(pick_pixel(100), i == 0);
        drain_results();
    endtask

    task automatic test_random_frames();
        int unsigned           first;
        int unsigned           sel;
        int unsigned           w;
        int unsigned           k;
        logic [CFG_DATA_W-1:0] data;
        first = sent_pixels;
        while (sent_pixels - first < RANDOM_PIXELS) begin
            drain_results();
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                w = $urandom_range(1, 12);
                k = $urandom_range(1, (w < 5) ? w : 5);
            end else if (sel < 8) begin
                w = $urandom_range(6, 24);
                k = $urandom_range(5, 8);
            end else if (sel == 8) begin
                w = $urandom_range(1, 8);
                k = $urandom_range(9, 31);
            end else begin
                w = $urandom_range(0, 1) ? 0 : 3;
                k = 0;
            end
            data = 16'($urandom);
            data[CFG_WIDTH_W-1:0] = w[CFG_WIDTH_W-1:0];
            write_reg(CFG_IDX_IMAGE_WIDTH, data);
            data = 16'($urandom);
            data[CFG_SQUARE_W-1:0] = k[CFG_SQUARE_W-1:0];
            write_reg(CFG_IDX_SQUARE_SIZE, data);
            sel = $urandom_range(0, 9);
            write_reg(CFG_IDX_THRESHOLD,
                      (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom));
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(60, 95));
        end
        quiet = 1'b0;
        drain_results();
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!quiet && gap_left == 0 &&
                ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0))
                gap_left = gap_len();
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (gap_left != 0) begin
                m_tready <= 1'b0;
                gap_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        square_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: square_found %0d square_count %0d",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.found) begin
                    $error("square_found: expected %0d, actual %0d", want.found, m_tuser);
                    mismatches++;
                end
                if (m_tdata !== want.count) begin
                    $error("square_count: expected %0d, actual %0d", want.count, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_config_extremes();
        test_clamped_config();
        test_width_change();
        test_back_pressure();
        test_largest_square();
        test_random_frames();
        drain_results();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
